@@ rtl/core/wfd_pkg.sv @@
// Weather frame decoder package: frame geometry, digest constants, codes and shared types.
// No dependencies; compiled first.

package wfd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int DIGEST_BYTES = 23;
    localparam int DIG_START    = FRAME_BYTES - DIGEST_BYTES;
    localparam int CELLS        = FRAME_BYTES - 1;
    localparam int CNT_W        = $clog2(FRAME_BYTES + 1);
    localparam int SNAP_LO      = DIG_START;
    localparam int SNAP_HI      = 21;

    localparam logic [7:0]  WHITEN       = 8'hAA;
    localparam logic [15:0] DG_GEN       = 16'h8810;
    localparam logic [15:0] DG_KEY       = 16'hBA95;
    localparam logic [15:0] DG_XOR       = 16'h6DF1;
    localparam logic [3:0]  TYPE_WEATHER = 4'h1;
    localparam logic [7:0]  BATT_MASK    = 8'h06;
    localparam logic [15:0] ID_ALL_ONES  = 16'hFFFF;

    localparam logic [4:0]  STORM_LEVEL_RST   = 5'd16;
    localparam logic [7:0]  STORM_TRIGGER_RST = 8'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LENGTH      = 3'd1,
        ST_DIGEST      = 3'd2,
        ST_NOT_WEATHER = 3'd3,
        ST_ID_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_SENSOR_ID     = 2'd0,
        CFG_STORM_LEVEL   = 2'd1,
        CFG_STORM_TRIGGER = 2'd2
    } cfg_idx_t;

    // frame as seen on the last byte, de-whitened
    typedef struct packed {
        logic                       len_ok;
        logic                       dig_ok;
        logic [SNAP_HI:SNAP_LO][7:0] m;
    } snap_t;

    // raw decoded readings, before saturation and ID check
    typedef struct packed {
        status_t            status;
        logic [15:0]        fid;
        logic signed [13:0] temp;
        logic [7:0]         hum;
        logic [20:0]        rain;
        logic [10:0]        gust;
        logic [15:0]        gust36;
        logic [10:0]        avg;
        logic [10:0]        dir;
        logic [17:0]        light;
        logic [10:0]        uv;
        logic               batt;
    } raw_t;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] mix;
    } dg_step_t;

    // one byte of the LFSR digest, msb first
    function automatic dg_step_t dg_step(logic [7:0] data, logic [15:0] key_in);
        dg_step_t    r;
        logic [15:0] k;
        k     = key_in;
        r.mix = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (data[i])
            begin
                r.mix = r.mix ^ k;
            end
            k = k[0] ? ((k >> 1) ^ DG_GEN) : (k >> 1);
        end
        r.key = k;
        return r;
    endfunction

endpackage

@@ rtl/core/wfd_if.sv @@
// Handshake channels of the weather frame decoder: byte input, result output, register writes.
// Depends on wfd_pkg.

interface wfd_byte_if;
    import wfd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;
    modport source (output valid, rx_byte, last_byte, input ready);
    modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface wfd_result_if;
    import wfd_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        frame_id;
    logic signed [13:0] temp_centi;
    logic [6:0]         humidity;
    logic [19:0]        rain_tenth_mm;
    logic [9:0]         gust_speed;
    logic [9:0]         avg_speed;
    logic [9:0]         wind_heading;
    logic [16:0]        light_level;
    logic [9:0]         uv_level;
    logic               battery_ok;
    logic               storm_flag;
    modport source (output valid, status, frame_id, temp_centi, humidity, rain_tenth_mm,
                    gust_speed, avg_speed, wind_heading, light_level, uv_level,
                    battery_ok, storm_flag, input ready);
    modport sink   (input valid, status, frame_id, temp_centi, humidity, rain_tenth_mm,
                    gust_speed, avg_speed, wind_heading, light_level, uv_level,
                    battery_ok, storm_flag, output ready);
endinterface

interface wfd_cfg_if;
    import wfd_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/wfd_cell.sv @@
// One byte cell of the frame shift chain; takes its neighbour's byte on each accepted word.
// No package dependency.

module wfd_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = shift ? d : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

@@ rtl/core/wfd_digest.sv @@
// Running LFSR-16 digest, one byte per accepted word, restarted at the frame head.
// Depends on wfd_pkg.

module wfd_digest (
    input  logic                      clk,
    input  logic                      step,
    input  logic [wfd_pkg::CNT_W-1:0] count,
    input  logic [7:0]                data,
    output logic [15:0]               sum_final
);
    import wfd_pkg::*;

    logic [15:0] key_reg;
    logic [15:0] key_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    dg_step_t    st;

    assign st        = dg_step(data, key_reg);
    assign sum_final = sum_reg ^ st.mix;

    always_comb
    begin
        key_next = key_reg;
        sum_next = sum_reg;
        if (step)
        begin
            if (count < CNT_W'(DIG_START))
            begin
                key_next = DG_KEY;
                sum_next = '0;
            end
            else
            begin
                key_next = st.key;
                sum_next = sum_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        sum_reg <= sum_next;
    end

endmodule

@@ rtl/core/wfd_decode.sv @@
// Second pipe stage: frame status checks and BCD to binary conversion of the readings.
// Depends on wfd_pkg.

module wfd_decode (
    input  logic          clk,
    input  logic          load,
    input  wfd_pkg::snap_t snap,
    output wfd_pkg::raw_t  raw
);
    import wfd_pkg::*;

    raw_t               raw_reg;
    raw_t               raw_next;
    logic [10:0]        t;
    logic signed [11:0] t_adj;
    logic signed [13:0] t_ext;

    function automatic logic [10:0] bcd3(logic [3:0] a, logic [3:0] b, logic [3:0] c);
        return 11'(a) * 11'd100 + 11'(b) * 11'd10 + 11'(c);
    endfunction

    always_comb
    begin
        raw_next = '0;
        if (!snap.len_ok)
        begin
            raw_next.status = ST_LENGTH;
        end
        else if (!snap.dig_ok)
        begin
            raw_next.status = ST_DIGEST;
        end
        else if ((snap.m[6][7:4] ^ WHITEN[7:4]) != TYPE_WEATHER)
        begin
            raw_next.status = ST_NOT_WEATHER;
        end
        else
        begin
            raw_next.status = ST_OK;
        end

        if (raw_next.status != ST_LENGTH && raw_next.status != ST_DIGEST)
        begin
            raw_next.fid = {snap.m[2], snap.m[3]};
        end

        raw_next.dir    = bcd3(snap.m[4][7:4], snap.m[4][3:0], snap.m[5][7:4]);
        raw_next.gust   = bcd3(snap.m[7][7:4], snap.m[7][3:0], snap.m[8][7:4]);
        raw_next.gust36 = 16'(raw_next.gust) * 16'd36;
        raw_next.avg    = bcd3(snap.m[8][3:0], snap.m[9][7:4], snap.m[9][3:0]);
        raw_next.uv     = bcd3(snap.m[20][7:4], snap.m[20][3:0], snap.m[21][7:4]);
        raw_next.hum    = 8'(snap.m[16][7:4]) * 8'd10 + 8'(snap.m[16][3:0]);

        raw_next.rain = 21'(snap.m[10][7:4]) * 21'd100000 + 21'(snap.m[10][3:0]) * 21'd10000
                      + 21'(snap.m[11][7:4]) * 21'd1000 + 21'(snap.m[11][3:0]) * 21'd100
                      + 21'(snap.m[12][7:4]) * 21'd10 + 21'(snap.m[12][3:0]);

        // lowest digit dropped; a units nibble of ten or more carries one
        raw_next.light = 18'(snap.m[17][7:4]) * 18'd10000 + 18'(snap.m[17][3:0]) * 18'd1000
                       + 18'(snap.m[18][7:4]) * 18'd100 + 18'(snap.m[18][3:0]) * 18'd10
                       + 18'(snap.m[19][7:4]) + 18'(snap.m[19][3:0] > 4'd9);

        t     = bcd3(snap.m[14][7:4], snap.m[14][3:0], snap.m[15][7:4]);
        t_adj = (t > 11'd600) ? ($signed({1'b0, t}) - 12'sd1000) : $signed({1'b0, t});
        t_ext = {{2{t_adj[11]}}, t_adj};
        raw_next.temp = (t_ext <<< 3) + (t_ext <<< 1);

        raw_next.batt = ((snap.m[15] & BATT_MASK) != BATT_MASK);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw = raw_reg;

endmodule

@@ rtl/core/weather_frame_decoder.sv @@
// Weather frame decoder top level: byte cell chain, digest, decode stage, ID and storm state.
// Depends on wfd_pkg, wfd_if, wfd_cell, wfd_digest, wfd_decode.
//
//   channel | dir | word
//   rx      | in  | rx_byte, last_byte
//   res     | out | status, frame_id and readings
//   cfg     | in  | index, data (write only)
//
// One byte is taken each cycle while rx.ready is high; cfg is always ready.
// res.valid rises once the frame has passed the snapshot, decode and output registers in turn.
// rx.ready falls only when the result pipe is full and res.ready is low.
// Reset clears counters, learnt ID and storm flag, and presets the storm count.

module weather_frame_decoder (
    input  logic            clk,
    input  logic            rst_n,
    wfd_byte_if.sink        rx,
    wfd_result_if.source    res,
    wfd_cfg_if.sink         cfg
);
    import wfd_pkg::*;

    logic [7:0] cell_d [CELLS];
    logic [7:0] cell_q [CELLS];

    logic in_fire;
    logic frame_end;
    logic cfg_fire;
    logic out_free;
    logic s1_free;
    logic s1_fire;
    logic s2_free;
    logic s2_fire;

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic             overflow_reg;
    logic             overflow_next;

    logic [15:0] sum_final;
    logic [7:0]  rx_clear;

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    logic  out_valid_reg;
    snap_t snap_reg;
    snap_t snap_next;
    raw_t  raw;

    logic [15:0] sensor_id_reg;
    logic [4:0]  storm_level_reg;
    logic [7:0]  storm_trigger_reg;
    logic [15:0] learned_id_reg;
    logic [15:0] learned_id_next;
    logic        id_learned_reg;
    logic        id_learned_next;
    logic [7:0]  storm_count_reg;
    logic [7:0]  storm_count_next;
    logic        stormy_reg;
    logic        stormy_next;

    logic [15:0] active_id;
    logic        learn;
    logic        good;
    logic [15:0] level_x500;
    status_t     status_next;

    status_t            status_reg;
    logic [15:0]        frame_id_reg;
    logic signed [13:0] temp_reg;
    logic [6:0]         hum_reg;
    logic [19:0]        rain_reg;
    logic [9:0]         gust_reg;
    logic [9:0]         avg_reg;
    logic [9:0]         dir_reg;
    logic [16:0]        light_reg;
    logic [9:0]         uv_reg;
    logic               batt_reg;
    logic               storm_flag_reg;

    function automatic logic [9:0] sat10(logic [10:0] v);
        return v[10] ? 10'h3FF : v[9:0];
    endfunction

    assign out_free  = !out_valid_reg || res.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s2_fire   = s2_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s1_fire   = s1_valid_reg && s2_free;
    assign rx.ready  = s1_free;
    assign in_fire   = rx.valid && s1_free;
    assign frame_end = in_fire && rx.last_byte;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    assign rx_clear = rx.rx_byte ^ WHITEN;

    // byte k of the frame sits in cell CELLS-1-k while byte CELLS is on the input
    genvar j;
    for (j = 0; j < CELLS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            assign cell_d[j] = rx_clear;
        end
        else
        begin : g_link
            assign cell_d[j] = cell_q[j-1];
        end
        wfd_cell u_cell (
            .clk   (clk),
            .shift (in_fire),
            .d     (cell_d[j]),
            .q     (cell_q[j])
        );
    end

    wfd_digest u_digest (
        .clk       (clk),
        .step      (in_fire),
        .count     (byte_count_reg),
        .data      (rx_clear),
        .sum_final (sum_final)
    );

    always_comb
    begin
        byte_count_next = byte_count_reg;
        overflow_next   = overflow_reg;
        if (in_fire)
        begin
            if (rx.last_byte)
            begin
                byte_count_next = '0;
                overflow_next   = 1'b0;
            end
            else if (byte_count_reg < CNT_W'(FRAME_BYTES))
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    always_comb
    begin
        snap_next        = '0;
        snap_next.len_ok = (byte_count_reg == CNT_W'(CELLS)) && !overflow_reg;
        snap_next.dig_ok = (({cell_q[CELLS-1], cell_q[CELLS-2]} ^ sum_final) == DG_XOR);
        for (int k = SNAP_LO; k <= SNAP_HI; k++)
        begin
            snap_next.m[k] = cell_q[CELLS-1-k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            snap_reg <= snap_next;
        end
    end

    wfd_decode u_decode (
        .clk  (clk),
        .load (s1_fire),
        .snap (snap_reg),
        .raw  (raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_end)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ID check, learning and storm hysteresis
    assign active_id  = id_learned_reg ? learned_id_reg : sensor_id_reg;
    assign learn      = (raw.status == ST_OK) && (active_id == '0 || active_id == ID_ALL_ONES);
    assign good       = (raw.status == ST_OK) && (learn || raw.fid == active_id);
    assign level_x500 = 16'(storm_level_reg) * 16'd500;

    always_comb
    begin
        status_next = raw.status;
        if (raw.status == ST_OK && !good)
        begin
            status_next = ST_ID_MISMATCH;
        end

        learned_id_next = learned_id_reg;
        id_learned_next = id_learned_reg;
        if (learn)
        begin
            learned_id_next = raw.fid;
            id_learned_next = 1'b1;
        end

        storm_count_next = storm_count_reg;
        stormy_next      = stormy_reg;
        if (good && storm_level_reg != '0)
        begin
            if (raw.gust36 >= level_x500)
            begin
                if (storm_count_reg != '0)
                begin
                    storm_count_next = storm_count_reg - 8'd1;
                end
                else
                begin
                    stormy_next = 1'b1;
                end
            end
            else
            begin
                if (storm_count_reg < storm_trigger_reg)
                begin
                    storm_count_next = storm_count_reg + 8'd1;
                end
                else
                begin
                    storm_count_next = storm_trigger_reg;
                end
                if (storm_count_next == storm_trigger_reg)
                begin
                    stormy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_id_reg     <= '0;
            storm_level_reg   <= STORM_LEVEL_RST;
            storm_trigger_reg <= STORM_TRIGGER_RST;
            learned_id_reg    <= '0;
            id_learned_reg    <= 1'b0;
            storm_count_reg   <= STORM_TRIGGER_RST;
            stormy_reg        <= 1'b0;
        end
        else
        begin
            if (s2_fire)
            begin
                learned_id_reg  <= learned_id_next;
                storm_count_reg <= storm_count_next;
                stormy_reg      <= stormy_next;
            end
            // a new sensor ID drops the learnt one
            if (cfg_fire && cfg.index == CFG_SENSOR_ID)
            begin
                id_learned_reg <= 1'b0;
            end
            else if (s2_fire)
            begin
                id_learned_reg <= id_learned_next;
            end
            if (cfg_fire)
            begin
                case (cfg.index)
                    CFG_SENSOR_ID:     sensor_id_reg     <= cfg.data;
                    CFG_STORM_LEVEL:   storm_level_reg   <= cfg.data[4:0];
                    CFG_STORM_TRIGGER: storm_trigger_reg <= cfg.data[7:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            status_reg     <= status_next;
            frame_id_reg   <= raw.fid;
            storm_flag_reg <= stormy_next;
            if (good)
            begin
                temp_reg  <= raw.temp;
                hum_reg   <= raw.hum[7] ? 7'h7F : raw.hum[6:0];
                rain_reg  <= raw.rain[20] ? 20'hFFFFF : raw.rain[19:0];
                gust_reg  <= sat10(raw.gust);
                avg_reg   <= sat10(raw.avg);
                dir_reg   <= sat10(raw.dir);
                light_reg <= raw.light[17] ? 17'h1FFFF : raw.light[16:0];
                uv_reg    <= sat10(raw.uv);
                batt_reg  <= raw.batt;
            end
            else
            begin
                temp_reg  <= '0;
                hum_reg   <= '0;
                rain_reg  <= '0;
                gust_reg  <= '0;
                avg_reg   <= '0;
                dir_reg   <= '0;
                light_reg <= '0;
                uv_reg    <= '0;
                batt_reg  <= 1'b0;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = status_reg;
    assign res.frame_id      = frame_id_reg;
    assign res.temp_centi    = temp_reg;
    assign res.humidity      = hum_reg;
    assign res.rain_tenth_mm = rain_reg;
    assign res.gust_speed    = gust_reg;
    assign res.avg_speed     = avg_reg;
    assign res.wind_heading  = dir_reg;
    assign res.light_level   = light_reg;
    assign res.uv_level      = uv_reg;
    assign res.battery_ok    = batt_reg;
    assign res.storm_flag    = storm_flag_reg;

endmodule

@@ rtl/core/wfd_checker.sv @@
// Port-level checks for the weather frame decoder, bound to the top level.
// Depends on wfd_pkg and weather_frame_decoder.

module wfd_props (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [2:0]         status,
    input logic [15:0]        frame_id,
    input logic signed [13:0] temp_centi,
    input logic [6:0]         humidity,
    input logic [19:0]        rain_tenth_mm,
    input logic [16:0]        light_level,
    input logic               battery_ok
);
    import wfd_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(frame_id))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status <= ST_ID_MISMATCH)
        else $error("status code out of range");

    a_err_readings: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> temp_centi == '0 && humidity == '0
            && rain_tenth_mm == '0 && light_level == '0 && !battery_ok)
        else $error("readings not cleared on failed frame");

    a_err_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_LENGTH || status == ST_DIGEST) |-> frame_id == '0)
        else $error("frame id shown on bad frame");

    a_rx_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("byte input stalled with empty output");

endmodule

bind weather_frame_decoder wfd_props u_wfd_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .status        (res.status),
    .frame_id      (res.frame_id),
    .temp_centi    (res.temp_centi),
    .humidity      (res.humidity),
    .rain_tenth_mm (res.rain_tenth_mm),
    .light_level   (res.light_level),
    .battery_ok    (res.battery_ok)
);
